// ===== src/srarq_pkg.sv =====
// Shared types, codes and reset values of the selective-repeat ARQ sender.
`default_nettype none

package srarq_pkg;

  // Field widths fixed by the request, result and configuration formats
  localparam int ID_W       = 7;
  localparam int OP_W       = 2;
  localparam int KIND_W     = 2;
  localparam int TIMEOUT_W  = 8;
  localparam int WINDOW_W   = 4;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Request operations
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_NACK = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FIRST   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NACK    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

  // Configuration reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd5;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 4'd3;
  localparam logic [COUNT_W-1:0]   COUNT_RST   = 7'd10;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] pkt_num;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]   send_id;
    logic [KIND_W-1:0] send_kind;
    logic              last;
  } result_t;

  // Configuration after clamping to legal ranges
  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic [WINDOW_W-1:0]  window;
    logic [COUNT_W-1:0]   count;
  } cfg_eff_t;

endpackage

`default_nettype wire

// ===== src/selective_repeat_arq_sender.sv =====
// Top level of the selective-repeat ARQ sender: sequencer over ack and timer memories.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-------------------------------------
//   request   | start, busy             | request (operation, pkt_num)
//   result    | result_valid (strobe)   | result (send_id, send_kind, last)
//   config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. A tick scans the
// in-flight packets (at most MAX_WINDOW) and may then send a new packet; an
// ACK slides the base past acknowledged packets already sent; a NACK resends
// its packet if still unacknowledged. A dropped request leaves busy low.
// Each scanned slot reads the ack bit and timer memories (registered read)
// and then writes back. Synchronous reset clears the control state; the ack
// memory needs no clearing pass because every entry below next_new has been
// written when its packet was first sent. Results are one-cycle strobes that
// cannot be stalled; the final result of a request leaves from a one-entry
// hold register as the request finishes, so it carries last.
`default_nettype none

module selective_repeat_arq_sender #(
  parameter int MAX_PACKETS = 64,
  parameter int MAX_WINDOW  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire srarq_pkg::request_t              request,
  output logic                                  busy,
  output logic                                  result_valid,
  output srarq_pkg::result_t                    result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srarq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srarq_pkg::CFG_DATA_W-1:0] cfg_data
);

  import srarq_pkg::*;

  // The count register is 7 bits, so packet indexes never pass 127
  localparam int CNT_MAX = (MAX_PACKETS < 127) ? MAX_PACKETS : 127;
  localparam int PW      = $clog2(CNT_MAX + 1);
  localparam int AW      = $clog2(CNT_MAX);
  localparam int SW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW      = $clog2(MAX_WINDOW + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_EV  = 3'd2;
  localparam logic [2:0] S_NEW      = 3'd3;
  localparam logic [2:0] S_NACK_EV  = 3'd4;
  localparam logic [2:0] S_SLIDE_RD = 3'd5;
  localparam logic [2:0] S_SLIDE_EV = 3'd6;
  localparam logic [2:0] S_FLUSH    = 3'd7;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SW'(MAX_WINDOW - 1)) ? '0 : s + 1'b1;
  endfunction

  cfg_eff_t eff;

  logic [2:0]    state;
  logic [PW-1:0] base;
  logic [SW-1:0] base_slot;
  logic [PW-1:0] next_new;
  logic [SW-1:0] next_slot;
  logic          finished;
  logic [PW-1:0] scan_p;
  logic [SW-1:0] scan_slot;
  logic [KW-1:0] scan_k;
  logic [PW-1:0] cur_p;
  logic [ID_W-1:0] cur_id;
  result_t       hold;
  logic          hold_valid;

  // Memory ports
  logic             ack_we;
  logic [AW-1:0]    ack_waddr;
  logic             ack_wdata;
  logic [AW-1:0]    ack_raddr;
  logic             ack_rd;
  logic             tm_we;
  logic [SW-1:0]    tm_waddr;
  logic [TIMEOUT_W-1:0] tm_wdata;
  logic [TIMEOUT_W-1:0] tm_rd;

  // Decode
  logic          accept;
  logic [ID_W-1:0] req_p;
  logic          req_ok;
  logic          scan_end;
  logic          new_ok;
  logic          slide_go;
  logic          base_done;
  logic          nack_ok;
  logic [PW-1:0] nack_dist;
  logic [SW:0]   nack_sum;
  logic [SW-1:0] nack_slot;
  logic          timer_expired;
  logic          emit_en;
  result_t       emit_res;
  logic          flush_out;

  srarq_cfg #(
    .MAX_PACKETS (MAX_PACKETS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff       (eff)
  );

  // Acknowledged bit per packet
  srarq_ram #(
    .DEPTH (CNT_MAX),
    .WIDTH (1)
  ) u_ack_ram (
    .clk   (clk),
    .we    (ack_we),
    .waddr (ack_waddr),
    .wdata (ack_wdata),
    .raddr (ack_raddr),
    .rdata (ack_rd)
  );

  // Retransmit timer per window slot
  srarq_ram #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (TIMEOUT_W)
  ) u_timer_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (scan_slot),
    .rdata (tm_rd)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // ACK and NACK must name a packet in 1..count that has already been sent
  assign req_p  = request.pkt_num - ID_W'(1);
  assign req_ok = (request.pkt_num != '0) && (request.pkt_num <= eff.count) &&
                  (req_p < ID_W'(next_new));

  assign scan_end  = (scan_k == KW'(MAX_WINDOW)) || (scan_p >= next_new) ||
                     (COUNT_W'(scan_p) >= eff.count);
  assign new_ok    = (COUNT_W'(next_new) < eff.count) &&
                     (8'(next_new) < 8'(base) + 8'(eff.window));
  assign slide_go  = (COUNT_W'(base) < eff.count) && (base < next_new);
  assign base_done = (COUNT_W'(base) >= eff.count);
  assign nack_ok   = !ack_rd && (cur_p >= base);

  // A NACKed packet lies within MAX_WINDOW of the base, so one wrap suffices
  assign nack_dist = cur_p - base;
  assign nack_sum  = (SW+1)'(base_slot) + (SW+1)'(nack_dist);
  assign nack_slot = (nack_sum >= (SW+1)'(MAX_WINDOW)) ?
                     SW'(nack_sum - (SW+1)'(MAX_WINDOW)) : SW'(nack_sum);

  assign timer_expired = (tm_rd <= TIMEOUT_W'(1));
  assign flush_out     = (state == S_FLUSH) && hold_valid;

  // Memory read and write selection
  always_comb begin
    ack_raddr = '0;
    ack_we    = 1'b0;
    ack_waddr = '0;
    ack_wdata = 1'b0;
    tm_we     = 1'b0;
    tm_waddr  = scan_slot;
    tm_wdata  = eff.timeout;
    unique case (state)
      S_IDLE: begin
        ack_raddr = AW'(req_p);
        ack_we    = accept && !finished && (request.operation == OP_ACK) && req_ok;
        ack_waddr = AW'(req_p);
        ack_wdata = 1'b1;
      end
      S_SCAN_RD: begin
        ack_raddr = AW'(scan_p);
      end
      S_SCAN_EV: begin
        tm_we    = !ack_rd;
        tm_waddr = scan_slot;
        tm_wdata = timer_expired ? eff.timeout : tm_rd - TIMEOUT_W'(1);
      end
      S_NEW: begin
        // Writing the fresh packet's ack bit keeps every entry below next_new valid
        ack_we    = new_ok;
        ack_waddr = AW'(next_new);
        ack_wdata = 1'b0;
        tm_we     = new_ok;
        tm_waddr  = next_slot;
      end
      S_NACK_EV: begin
        tm_we    = nack_ok;
        tm_waddr = nack_slot;
      end
      S_SLIDE_RD: begin
        ack_raddr = AW'(base);
      end
      S_SLIDE_EV: ;
      S_FLUSH: ;
    endcase
  end

  // Result produced in this cycle, before it is known whether it is the last
  always_comb begin
    emit_en  = 1'b0;
    emit_res = '{send_id: '0, send_kind: KIND_FIRST, last: 1'b0};
    unique case (state)
      S_SCAN_EV: begin
        if (!ack_rd && timer_expired) begin
          emit_en  = 1'b1;
          emit_res = '{send_id: ID_W'(scan_p) + ID_W'(1), send_kind: KIND_TIMEOUT,
                       last: 1'b0};
        end
      end
      S_NEW: begin
        if (new_ok) begin
          emit_en  = 1'b1;
          emit_res = '{send_id: ID_W'(next_new) + ID_W'(1), send_kind: KIND_FIRST,
                       last: 1'b0};
        end
      end
      S_NACK_EV: begin
        if (nack_ok) begin
          emit_en  = 1'b1;
          emit_res = '{send_id: cur_id, send_kind: KIND_NACK, last: 1'b0};
        end
      end
      S_SLIDE_RD: begin
        if (!slide_go && base_done) begin
          emit_en  = 1'b1;
          emit_res = '{send_id: ID_W'(eff.count), send_kind: KIND_DONE, last: 1'b0};
        end
      end
      S_SLIDE_EV: begin
        if (!ack_rd && base_done) begin
          emit_en  = 1'b1;
          emit_res = '{send_id: ID_W'(eff.count), send_kind: KIND_DONE, last: 1'b0};
        end
      end
      S_IDLE: ;
      S_SCAN_RD: ;
      S_FLUSH: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base         <= '0;
      base_slot    <= '0;
      next_new     <= '0;
      next_slot    <= '0;
      finished     <= 1'b0;
      scan_p       <= '0;
      scan_slot    <= '0;
      scan_k       <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Push the previous held result out when a new one arrives, or the held one as the last in the flush state
      result_valid <= (emit_en && hold_valid) || flush_out;
      if (emit_en) begin
        hold_valid <= 1'b1;
      end else if (flush_out) begin
        hold_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && !finished) begin
            priority if (request.operation == OP_TICK) begin
              scan_p    <= base;
              scan_slot <= base_slot;
              scan_k    <= '0;
              state     <= S_SCAN_RD;
            end else if (request.operation == OP_ACK && req_ok) begin
              state <= S_SLIDE_RD;
            end else if (request.operation == OP_NACK && req_ok) begin
              state <= S_NACK_EV;
            end else begin
              // Drop unknown operations and ids out of range or never sent
              state <= S_IDLE;
            end
          end
        end
        S_SCAN_RD: begin
          state <= scan_end ? S_NEW : S_SCAN_EV;
        end
        S_SCAN_EV: begin
          scan_p    <= scan_p + 1'b1;
          scan_slot <= slot_inc(scan_slot);
          scan_k    <= scan_k + 1'b1;
          state     <= S_SCAN_RD;
        end
        S_NEW: begin
          if (new_ok) begin
            next_new  <= next_new + 1'b1;
            next_slot <= slot_inc(next_slot);
          end
          state <= S_FLUSH;
        end
        S_NACK_EV: begin
          state <= S_FLUSH;
        end
        S_SLIDE_RD: begin
          if (slide_go) begin
            state <= S_SLIDE_EV;
          end else begin
            finished <= base_done;
            state    <= S_FLUSH;
          end
        end
        S_SLIDE_EV: begin
          if (ack_rd) begin
            base      <= base + 1'b1;
            base_slot <= slot_inc(base_slot);
            state     <= S_SLIDE_RD;
          end else begin
            finished <= base_done;
            state    <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request operands and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cur_p  <= PW'(req_p);
      cur_id <= request.pkt_num;
    end
    if (emit_en) begin
      if (hold_valid) begin
        result <= hold;
      end
      hold <= emit_res;
    end else if (flush_out) begin
      result <= '{send_id: hold.send_id, send_kind: hold.send_kind, last: 1'b1};
    end
  end

endmodule

`default_nettype wire

// ===== src/srarq_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module srarq_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/srarq_cfg.sv =====
// Configuration registers and their clamped effective values.
`default_nettype none

module srarq_cfg #(
  parameter int MAX_PACKETS = 64,
  parameter int MAX_WINDOW  = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [srarq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [srarq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output srarq_pkg::cfg_eff_t                       eff
);

  import srarq_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [WINDOW_W-1:0]  win_len;
  logic [COUNT_W-1:0]   pkt_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      win_len       <= WINDOW_RST;
      pkt_total     <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        CFG_WINDOW:  win_len       <= cfg_data[WINDOW_W-1:0];
        CFG_COUNT:   pkt_total     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; oversized values saturate at the built-in limits
  always_comb begin
    eff.timeout = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;

    if (win_len == '0) begin
      eff.window = WINDOW_W'(1);
    end else if (32'(win_len) > 32'(MAX_WINDOW)) begin
      eff.window = WINDOW_W'(MAX_WINDOW);
    end else begin
      eff.window = win_len;
    end

    if (pkt_total == '0) begin
      eff.count = COUNT_W'(1);
    end else if (32'(pkt_total) > 32'(MAX_PACKETS)) begin
      eff.count = COUNT_W'(MAX_PACKETS);
    end else begin
      eff.count = pkt_total;
    end
  end

endmodule

`default_nettype wire

// ===== src/srarq_checker.sv =====
// Port-level checks for the selective-repeat ARQ sender, bound to the top level.
`default_nettype none

module srarq_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                busy,
  input wire logic                result_valid,
  input wire srarq_pkg::result_t  result
);

  import srarq_pkg::*;

  // Reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

  // The done result always closes its request
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.send_kind == KIND_DONE) |-> result.last)
    else $error("done result without last");

  // A result that is not the last one means the request is still running
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("non-last result while idle");

  // Nothing follows the last result in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result right after a last result");

  // Packet ids start at one
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.send_id != '0))
    else $error("result with packet id zero");

endmodule

bind selective_repeat_arq_sender srarq_checker u_srarq_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire
